// ===== rtl/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// iss_pkg: shared types and constants for the indexed sequence store
// Sizes of the entry row, request and status codes, and the per-cell
// control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

  // Row size and widths
  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 5;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_READ   = 3'd2,
    REQ_WRITE  = 3'd3,
    REQ_FIND   = 3'd4,
    REQ_CLEAR  = 3'd5
  } iss_req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } iss_status_t;

  // Per-cell update command
  typedef struct packed {
    logic load;     // take the incoming item's handle
    logic take_lo;  // take the handle of the lower neighbor (insert shift)
    logic take_hi;  // take the handle of the upper neighbor (remove shift)
  } iss_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store: ordered list of handles kept in a row of cells
// Insert, remove, read, write, find and clear on a list of up to CAPACITY
// handles.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_req_type, in_position and in_element_in; the item is
//   taken at a rising edge where start is high and busy is low. busy stays
//   low, so a new item may be issued in every cycle.
//   Each item gives one result: out_valid is high for exactly one cycle, the
//   cycle after the item is taken, with out_status, out_element_out,
//   out_found_index and out_count (length after the item).
//   Throughput is 1 item per cycle: every cell of the row shifts, loads and
//   compares in the same cycle, and the length register and the result
//   register update at the same edge.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result. Cell contents are not reset; a position is read only after it
//   has been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [iss_pkg::REQ_W-1:0]     in_req_type,
  input  logic [iss_pkg::POS_W-1:0]     in_position,
  input  logic [iss_pkg::ELEM_BITS-1:0] in_element_in,
  output logic                          out_valid,
  output logic [iss_pkg::STAT_W-1:0]    out_status,
  output logic [iss_pkg::ELEM_BITS-1:0] out_element_out,
  output logic [iss_pkg::IDX_W-1:0]     out_found_index,
  output logic [iss_pkg::CNT_W-1:0]     out_count
);

  logic                          accept;
  logic [iss_pkg::CNT_W-1:0]     len_r;
  logic [iss_pkg::CNT_W-1:0]     len_nxt;
  logic                          pos_in_len;
  logic                          pos_le_len;
  logic                          full;
  logic                          do_ins;
  logic                          do_rem;
  logic                          do_wr;
  logic                          find_hit;
  logic [iss_pkg::IDX_W-1:0]     find_idx;
  logic [iss_pkg::ELEM_BITS-1:0] rd_elem;
  iss_pkg::iss_status_t          status_nxt;
  logic [iss_pkg::ELEM_BITS-1:0] data_nxt;
  logic [iss_pkg::IDX_W-1:0]     fidx_nxt;

  logic [iss_pkg::ELEM_BITS-1:0] cell_entry [iss_pkg::CAPACITY];
  logic [iss_pkg::CAPACITY-1:0]  cell_match;
  logic [iss_pkg::CAPACITY-1:0]  cell_valid;

  logic                          out_valid_r;
  iss_pkg::iss_status_t          out_status_r;
  logic [iss_pkg::ELEM_BITS-1:0] out_element_r;
  logic [iss_pkg::IDX_W-1:0]     out_found_index_r;
  logic [iss_pkg::CNT_W-1:0]     out_count_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_in_len = (iss_pkg::CNT_W'(in_position) < len_r) &&
                      (in_position < iss_pkg::POS_W'(iss_pkg::CAPACITY));
  assign pos_le_len = (iss_pkg::CNT_W'(in_position) <= len_r) &&
                      (in_position <= iss_pkg::POS_W'(iss_pkg::CAPACITY));
  assign full       = (len_r == iss_pkg::CNT_W'(iss_pkg::CAPACITY));
  assign rd_elem    = cell_entry[in_position[iss_pkg::IDX_W-1:0]];

  // Decode the request into cell commands, new length and result
  always_comb begin
    status_nxt = iss_pkg::ST_OK;
    data_nxt   = '0;
    fidx_nxt   = '0;
    len_nxt    = len_r;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_wr      = 1'b0;
    unique case (iss_pkg::iss_req_t'(in_req_type))
      iss_pkg::REQ_INSERT: begin
        if (!pos_le_len) begin
          status_nxt = iss_pkg::ST_RANGE;
        end else if (full) begin
          status_nxt = iss_pkg::ST_FULL;
        end else begin
          do_ins  = accept;
          len_nxt = len_r + iss_pkg::CNT_W'(1);
        end
      end
      iss_pkg::REQ_REMOVE: begin
        if (!pos_in_len) begin
          status_nxt = iss_pkg::ST_RANGE;
        end else begin
          data_nxt = rd_elem;
          do_rem   = accept;
          len_nxt  = len_r - iss_pkg::CNT_W'(1);
        end
      end
      iss_pkg::REQ_READ: begin
        if (!pos_in_len) begin
          status_nxt = iss_pkg::ST_RANGE;
        end else begin
          data_nxt = rd_elem;
        end
      end
      iss_pkg::REQ_WRITE: begin
        if (!pos_in_len) begin
          status_nxt = iss_pkg::ST_RANGE;
        end else begin
          do_wr = accept;
        end
      end
      iss_pkg::REQ_FIND: begin
        if (find_hit) begin
          fidx_nxt = find_idx;
        end else begin
          status_nxt = iss_pkg::ST_NOTFOUND;
        end
      end
      iss_pkg::REQ_CLEAR: begin
        len_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Row of cells, each driven by its own slice of the command
  for (genvar i = 0; i < iss_pkg::CAPACITY; i++) begin : g_cell
    iss_pkg::iss_cell_ctrl_t       ctrl;
    logic [iss_pkg::ELEM_BITS-1:0] lo_elem;
    logic [iss_pkg::ELEM_BITS-1:0] hi_elem;
    logic                          at_pos;
    logic                          above_pos;

    assign at_pos    = (in_position == iss_pkg::POS_W'(i));
    assign above_pos = (in_position < iss_pkg::POS_W'(i));

    assign ctrl.load    = (do_ins || do_wr) && at_pos;
    assign ctrl.take_lo = do_ins && above_pos &&
                          (iss_pkg::CNT_W'(i) <= len_r);
    assign ctrl.take_hi = do_rem && (at_pos || above_pos) &&
                          (iss_pkg::CNT_W'(i + 1) < len_r);

    assign cell_valid[i] = (iss_pkg::CNT_W'(i) < len_r);

    if (i == 0) begin : g_lo_edge
      assign lo_elem = '0;
    end else begin : g_lo_link
      assign lo_elem = cell_entry[i-1];
    end

    if (i == iss_pkg::CAPACITY - 1) begin : g_hi_edge
      assign hi_elem = '0;
    end else begin : g_hi_link
      assign hi_elem = cell_entry[i+1];
    end

    iss_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_elem (in_element_in),
      .lo_elem  (lo_elem),
      .hi_elem  (hi_elem),
      .key      (in_element_in),
      .entry    (cell_entry[i]),
      .match    (cell_match[i])
    );
  end

  iss_find u_find (
    .match (cell_match),
    .valid (cell_valid),
    .hit   (find_hit),
    .idx   (find_idx)
  );

  // Advance the length and register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        len_r <= len_nxt;
      end
    end
    if (accept) begin
      out_status_r      <= status_nxt;
      out_element_r     <= data_nxt;
      out_found_index_r <= fidx_nxt;
      out_count_r       <= len_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element_out = out_element_r;
  assign out_found_index = out_found_index_r;
  assign out_count       = out_count_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= iss_pkg::CNT_W'(iss_pkg::CAPACITY))
    else $error("list length above capacity");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without an accepted item");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == iss_pkg::ST_FULL) |->
      (out_count == iss_pkg::CNT_W'(iss_pkg::CAPACITY)))
    else $error("full status on a list that is not full");

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != iss_pkg::ST_OK) |-> (out_element_out == '0))
    else $error("failed request returned a handle");
`endif

endmodule

`default_nettype wire

// ===== rtl/iss_cell.sv =====
// ----------------------------------------------------------------------------
// iss_cell: one entry of the sequence row
// Holds a handle, shifts from either neighbor or loads a new handle, and
// compares its handle against the search key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iss_cell (
  input  logic                          clk,
  input  iss_pkg::iss_cell_ctrl_t       ctrl,
  input  logic [iss_pkg::ELEM_BITS-1:0] new_elem,
  input  logic [iss_pkg::ELEM_BITS-1:0] lo_elem,
  input  logic [iss_pkg::ELEM_BITS-1:0] hi_elem,
  input  logic [iss_pkg::ELEM_BITS-1:0] key,
  output logic [iss_pkg::ELEM_BITS-1:0] entry,
  output logic                          match
);

  logic [iss_pkg::ELEM_BITS-1:0] entry_r;
  logic [iss_pkg::ELEM_BITS-1:0] entry_nxt;

  // Pick the next handle: load wins, then shifts, else hold
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load) begin
      entry_nxt = new_elem;
    end else if (ctrl.take_lo) begin
      entry_nxt = lo_elem;
    end else if (ctrl.take_hi) begin
      entry_nxt = hi_elem;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r == key);

endmodule

`default_nettype wire

// ===== rtl/iss_find.sv =====
// ----------------------------------------------------------------------------
// iss_find: first-match encoder over the cell row
// Reports whether any valid cell matches and the lowest such position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iss_find (
  input  logic [iss_pkg::CAPACITY-1:0] match,
  input  logic [iss_pkg::CAPACITY-1:0] valid,
  output logic                         hit,
  output logic [iss_pkg::IDX_W-1:0]    idx
);

  logic [iss_pkg::CAPACITY-1:0] live;

  assign live = match & valid;
  assign hit  = |live;

  // Scan from the top so the lowest matching position wins
  always_comb begin
    idx = '0;
    for (int i = iss_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (live[i]) begin
        idx = iss_pkg::IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
